/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/omm_pkg.sv */
// Shared types, codes, constants and the vector ROM of the overlay memory map.
package omm_pkg;

  localparam int NUM_OVERLAYS_DEF  = 8;
  localparam int OVERLAY_BYTES_DEF = 32;
  localparam int CODE_BYTES_DEF    = 256;

  localparam int ZP_DEPTH = 256;
  localparam logic [15:0] CODE_BASE = 16'h0300;

  localparam logic [7:0] PAGE_ZERO = 8'h00;
  localparam logic [7:0] PAGE_IO   = 8'h02;
  localparam logic [7:0] PAGE_VEC  = 8'hff;
  localparam logic [7:0] VEC_START = 8'd240;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_HIT,
    S_ORD,
    S_FILL,
    S_PUT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       out_of_pages;
    logic [7:0] io_data;
    logic       io_is_write;
    logic [7:0] io_offset;
    logic       io_access;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic hit;
    logic full;
  } tag_stat_t;

  function automatic logic [7:0] vector_rom(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'd141;
      4'd1:    v = 8'd18;
      4'd2:    v = 8'd2;
      4'd3:    v = 8'd76;
      4'd4:    v = 8'd240;
      4'd5:    v = 8'd255;
      4'd10:   v = 8'd240;
      4'd11:   v = 8'd255;
      4'd12:   v = 8'd0;
      4'd13:   v = 8'd3;
      4'd14:   v = 8'd240;
      4'd15:   v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/overlay_memory_map.sv */
// Overlay memory map: I/O, vector, load and zero-page write accesses go from lookup to
// output; zero-page reads, overlay misses and write hits pass the hit state on the way;
// overlay read hits also pass the order state; a page that a write allocates is filled from
// the code store one byte a cycle, then written. A new request is taken only in idle.
// Reset clears the zero-page valid bits, the page count and code_length at once; the
// overlay bytes and the code store keep whatever they held until written.
module overlay_memory_map #(
  parameter int NUM_OVERLAYS  = omm_pkg::NUM_OVERLAYS_DEF,
  parameter int OVERLAY_BYTES = omm_pkg::OVERLAY_BYTES_DEF,
  parameter int CODE_BYTES    = omm_pkg::CODE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // code_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // address[15:0], value[23:16]
  input  logic [1:0]  in_tuser,      // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // read_data[7:0], io_offset[15:8], io_data[23:16],
                                     // out_of_pages[24], zero[31:25]
  output logic [1:0]  out_tuser      // io_access[0], io_is_write[1]
);

  // OVERLAY_BYTES is a power of two
  localparam int PW    = $clog2(OVERLAY_BYTES);
  localparam int TW    = 16 - PW;
  localparam int IW    = (NUM_OVERLAYS > 1) ? $clog2(NUM_OVERLAYS) : 1;
  localparam int CNTW  = $clog2(NUM_OVERLAYS + 1);
  localparam int CW    = $clog2(OVERLAY_BYTES + 1);
  localparam int CAW   = $clog2(CODE_BYTES);
  localparam int DDEPTH = omm_pkg::ZP_DEPTH + NUM_OVERLAYS * OVERLAY_BYTES;
  localparam int DAW   = $clog2(DDEPTH);

  omm_pkg::state_t  state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [15:0]      addr_r;
  logic [7:0]       val_r;
  logic [7:0]       code_len_r;
  omm_pkg::result_t res_r, res_nxt;
  omm_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic [omm_pkg::ZP_DEPTH-1:0] zp_valid_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic             fill_ok_r, fill_ok_nxt;

  logic             accept;
  logic             out_load;
  logic [7:0]       page;
  logic [7:0]       off;
  logic [PW-1:0]    pos;
  logic [15:0]      fill_a;
  logic [CW-1:0]    cnt_prev;
  logic             zp_set;

  logic             d_we, d_re, c_we, c_re;
  logic [DAW-1:0]   d_waddr, d_raddr;
  logic [7:0]       d_wdata, d_rdata;
  logic [CAW-1:0]   c_waddr, c_raddr;
  logic [7:0]       c_rdata;

  logic               tag_alloc;
  omm_pkg::tag_stat_t tag_stat;
  logic [IW-1:0]      hit_idx, free_idx;

  function automatic logic code_ok(input logic [15:0] a, input logic [7:0] len);
    return (a >= omm_pkg::CODE_BASE)
        && ({1'b0, a} < ({1'b0, omm_pkg::CODE_BASE} + {9'b0, len}))
        && (32'(a - omm_pkg::CODE_BASE) < CODE_BYTES);
  endfunction

  function automatic logic [CAW-1:0] code_idx(input logic [15:0] a);
    logic [15:0] d;
    d = a - omm_pkg::CODE_BASE;
    return d[CAW-1:0];
  endfunction

  function automatic logic [DAW-1:0] ov_addr(input logic [IW-1:0] idx,
                                             input logic [PW-1:0] p);
    return DAW'(omm_pkg::ZP_DEPTH + int'({idx, p}));
  endfunction

  assign page      = addr_r[15:8];
  assign off       = addr_r[7:0];
  assign pos       = addr_r[PW-1:0];
  assign fill_a    = {addr_r[15:PW], cnt_r[PW-1:0]};
  assign cnt_prev  = cnt_r - CW'(1);
  assign in_tready = (state_r == omm_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == omm_pkg::S_OUT) && (!out_valid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      omm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = omm_pkg::S_LOOK;
        end
      end
      omm_pkg::S_LOOK: begin
        if (mode_r == omm_pkg::MODE_LOAD || mode_r == omm_pkg::MODE_NONE) begin
          state_nxt = omm_pkg::S_OUT;
        end else if (page == omm_pkg::PAGE_ZERO) begin
          state_nxt = (mode_r == omm_pkg::MODE_READ) ? omm_pkg::S_HIT : omm_pkg::S_OUT;
        end else if (page == omm_pkg::PAGE_IO || page == omm_pkg::PAGE_VEC) begin
          state_nxt = omm_pkg::S_OUT;
        end else begin
          state_nxt = omm_pkg::S_HIT;
        end
      end
      omm_pkg::S_HIT: begin
        if (page == omm_pkg::PAGE_ZERO) begin
          state_nxt = omm_pkg::S_OUT;
        end else if (mode_r == omm_pkg::MODE_READ) begin
          state_nxt = tag_stat.hit ? omm_pkg::S_ORD : omm_pkg::S_OUT;
        end else if (tag_stat.hit || tag_stat.full) begin
          state_nxt = omm_pkg::S_OUT;
        end else begin
          state_nxt = omm_pkg::S_FILL;
        end
      end
      omm_pkg::S_ORD: state_nxt = omm_pkg::S_OUT;
      omm_pkg::S_FILL: begin
        if (cnt_r == CW'(OVERLAY_BYTES)) begin
          state_nxt = omm_pkg::S_PUT;
        end
      end
      omm_pkg::S_PUT: state_nxt = omm_pkg::S_OUT;
      omm_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = omm_pkg::S_IDLE;
        end
      end
      default: state_nxt = omm_pkg::S_IDLE;
    endcase
  end

  // Memory controls and result assembly
  always_comb begin
    res_nxt     = res_r;
    cnt_nxt     = cnt_r;
    slot_nxt    = slot_r;
    fill_ok_nxt = fill_ok_r;
    zp_set      = 1'b0;
    tag_alloc   = 1'b0;
    d_we        = 1'b0;
    d_waddr     = DAW'(off);
    d_wdata     = val_r;
    d_re        = 1'b0;
    d_raddr     = DAW'(off);
    c_we        = 1'b0;
    c_waddr     = off[CAW-1:0];
    c_re        = 1'b0;
    c_raddr     = code_idx(addr_r);
    case (state_r)
      omm_pkg::S_IDLE: begin
        res_nxt = '0;
      end
      omm_pkg::S_LOOK: begin
        if (mode_r == omm_pkg::MODE_LOAD) begin
          c_we = (32'(off) < CODE_BYTES);
        end else if (mode_r == omm_pkg::MODE_NONE) begin
          res_nxt = '0;
        end else if (page == omm_pkg::PAGE_ZERO) begin
          if (mode_r == omm_pkg::MODE_WRITE) begin
            d_we   = 1'b1;
            zp_set = 1'b1;
          end else begin
            d_re = 1'b1;
          end
        end else if (page == omm_pkg::PAGE_IO) begin
          res_nxt.io_access = 1'b1;
          res_nxt.io_offset = off;
          if (mode_r == omm_pkg::MODE_WRITE) begin
            res_nxt.io_is_write = 1'b1;
            res_nxt.io_data     = val_r;
          end
        end else if (page == omm_pkg::PAGE_VEC) begin
          if (mode_r == omm_pkg::MODE_READ && off >= omm_pkg::VEC_START) begin
            res_nxt.read_data = omm_pkg::vector_rom(off[3:0]);
          end
        end else begin
          c_re = 1'b1;
        end
      end
      omm_pkg::S_HIT: begin
        if (page == omm_pkg::PAGE_ZERO) begin
          res_nxt.read_data = zp_valid_r[off] ? d_rdata : 8'd0;
        end else if (mode_r == omm_pkg::MODE_READ) begin
          if (tag_stat.hit) begin
            d_re    = 1'b1;
            d_raddr = ov_addr(hit_idx, pos);
          end else begin
            res_nxt.read_data = code_ok(addr_r, code_len_r) ? c_rdata : 8'd0;
          end
        end else if (tag_stat.hit) begin
          d_we    = 1'b1;
          d_waddr = ov_addr(hit_idx, pos);
        end else if (tag_stat.full) begin
          res_nxt.out_of_pages = 1'b1;
        end else begin
          tag_alloc = 1'b1;
          slot_nxt  = free_idx;
          cnt_nxt   = '0;
        end
      end
      omm_pkg::S_ORD: begin
        res_nxt.read_data = d_rdata;
      end
      omm_pkg::S_FILL: begin
        // read byte cnt from the code store, write byte cnt-1 into the page
        if (cnt_r != CW'(OVERLAY_BYTES)) begin
          c_re        = 1'b1;
          c_raddr     = code_idx(fill_a);
          fill_ok_nxt = code_ok(fill_a, code_len_r);
        end
        if (cnt_r != '0) begin
          d_we    = 1'b1;
          d_waddr = ov_addr(slot_r, cnt_prev[PW-1:0]);
          d_wdata = fill_ok_r ? c_rdata : 8'd0;
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      omm_pkg::S_PUT: begin
        d_we    = 1'b1;
        d_waddr = ov_addr(slot_r, pos);
      end
      omm_pkg::S_OUT: begin
        res_nxt = res_r;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= omm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      code_len_r  <= '0;
      zp_valid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        code_len_r <= cfg_wdata;
      end
      if (zp_set) begin
        zp_valid_r[off] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_tuser;
      addr_r <= in_tdata[15:0];
      val_r  <= in_tdata[23:16];
    end
    res_r     <= res_nxt;
    cnt_r     <= cnt_nxt;
    slot_r    <= slot_nxt;
    fill_ok_r <= fill_ok_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  omm_ram #(
    .WIDTH (8),
    .DEPTH (DDEPTH),
    .AW    (DAW)
  ) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  omm_ram #(
    .WIDTH (8),
    .DEPTH (CODE_BYTES),
    .AW    (CAW)
  ) u_code_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (val_r),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  omm_tags #(
    .NUM  (NUM_OVERLAYS),
    .TW   (TW),
    .IW   (IW),
    .CNTW (CNTW)
  ) u_tags (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_tag (addr_r[15:PW]),
    .alloc      (tag_alloc),
    .alloc_tag  (addr_r[15:PW]),
    .stat       (tag_stat),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.out_of_pages, out_res_r.io_data,
                       out_res_r.io_offset, out_res_r.read_data};
  assign out_tuser  = {out_res_r.io_is_write, out_res_r.io_access};

endmodule

/* src/omm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module omm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/omm_tags.sv */
// Overlay page tag registers with a registered parallel match and page allocation.
module omm_tags #(
  parameter int NUM  = 8,
  parameter int TW   = 11,
  parameter int IW   = 3,
  parameter int CNTW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TW-1:0]      lookup_tag,
  input  logic               alloc,
  input  logic [TW-1:0]      alloc_tag,
  output omm_pkg::tag_stat_t stat,
  output logic [IW-1:0]      hit_idx,
  output logic [IW-1:0]      free_idx
);

  logic [TW-1:0]   tags_r [NUM];
  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] count_nxt;
  logic [NUM-1:0]  match_r;
  logic [NUM-1:0]  match_nxt;

  always_comb begin
    for (int i = 0; i < NUM; i++) begin
      match_nxt[i] = (CNTW'(i) < count_r) && (tags_r[i] == lookup_tag);
    end
  end

  // Tags are unique, so at most one match bit is set and an OR encodes it.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign count_nxt = alloc ? count_r + CNTW'(1) : count_r;
  assign free_idx  = count_r[IW-1:0];
  assign stat.hit  = |match_r;
  assign stat.full = (count_r == CNTW'(NUM));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    if (alloc) begin
      tags_r[free_idx] <= alloc_tag;
    end
  end

endmodule

/* src/omm_checker.sv */
// Port-level checker for the overlay memory map and its bind to the top level.
`include "assert_macros.svh"

module omm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [7:0]  cfg_wdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // hold a stalled result
  `OMM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `OMM_ASSERT_NOW(a_io_write_flag, out_tvalid && out_tuser[1], out_tuser[0], "I/O write flag without I/O access")

  `OMM_ASSERT_NOW(a_io_no_read, out_tvalid && out_tuser[0], out_tdata[7:0] == 8'd0 && !out_tdata[24], "I/O access carries read data or page flag")

  `OMM_ASSERT_NOW(a_oop_clean, out_tvalid && out_tdata[24], out_tdata[23:0] == 24'd0 && out_tuser == 2'd0, "dropped write carries other fields")

  // a request never yields a result in the very next cycle
  `OMM_ASSERT_NEXT(a_min_latency, in_tvalid && in_tready, !$rose(out_tvalid), "result appeared one cycle after request")

endmodule

bind overlay_memory_map omm_checker u_omm_checker (.*);

/* sim/overlay_memory_map_test.sv */
// Self-checking testbench for the overlay memory map with a bus access predictor.
`timescale 1ns / 100ps

module overlay_memory_map_test;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  localparam int PAGE_BYTES = 32;
  localparam int PAGE_SLOTS = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 110;

  // Predicts the result of every accepted bus access and checks results in order.
  class bus_result_board;
    logic [7:0] zp_ram [256];
    logic [10:0] page_tags [PAGE_SLOTS];
    logic [7:0] page_data [PAGE_SLOTS][PAGE_BYTES];
    int pages_used;
    logic [7:0] code_bytes [256];
    logic [7:0] code_len;
    logic [7:0] vec_table [16];
    omm_pkg::result_t pending_results[$];
    int mismatches;

    function new();
      foreach (zp_ram[i]) zp_ram[i] = '0;
      foreach (code_bytes[i]) code_bytes[i] = '0;
      pages_used = 0;
      code_len = '0;
      mismatches = 0;
      vec_table = '{8'd141, 8'd18, 8'd2, 8'd76, 8'd240, 8'd255, 8'd0, 8'd0,
                    8'd0, 8'd0, 8'd240, 8'd255, 8'd0, 8'd3, 8'd240, 8'd255};
    endfunction

    function void set_code_length(logic [7:0] len);
      code_len = len;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Program byte seen at a bus address; zero outside the loaded program.
    function logic [7:0] code_byte(logic [15:0] addr, bit page_one);
      int a;
      a = addr;
      if (page_one || a < omm_pkg::CODE_BASE ||
          a >= int'(omm_pkg::CODE_BASE) + int'(code_len)) return '0;
      return code_bytes[a - omm_pkg::CODE_BASE];
    endfunction

    function omm_pkg::result_t predict_access(logic [1:0] mode, logic [15:0] addr,
                                              logic [7:0] val);
      omm_pkg::result_t r;
      logic [7:0] pg;
      logic [7:0] off;
      logic [10:0] tag;
      logic [4:0] pos;
      int slot;
      r = '0;
      pg = addr[15:8];
      off = addr[7:0];
      tag = addr[15:5];
      pos = addr[4:0];
      slot = -1;
      if (mode == omm_pkg::MODE_LOAD) begin
        code_bytes[off] = val;
        return r;
      end
      if (mode == omm_pkg::MODE_NONE) return r;
      if (pg == omm_pkg::PAGE_ZERO) begin
        if (mode == omm_pkg::MODE_WRITE) zp_ram[off] = val;
        else r.read_data = zp_ram[off];
      end else if (pg == omm_pkg::PAGE_IO) begin
        r.io_access = 1'b1;
        r.io_offset = off;
        if (mode == omm_pkg::MODE_WRITE) begin
          r.io_is_write = 1'b1;
          r.io_data = val;
        end
      end else if (pg == omm_pkg::PAGE_VEC) begin
        if (mode == omm_pkg::MODE_READ && off >= omm_pkg::VEC_START)
          r.read_data = vec_table[off[3:0]];
      end else begin
        for (int i = 0; i < pages_used; i++)
          if (slot < 0 && page_tags[i] == tag) slot = i;
        if (mode == omm_pkg::MODE_READ) begin
          if (slot >= 0) r.read_data = page_data[slot][pos];
          else r.read_data = code_byte(addr, pg == 8'h01);
        end else begin
          if (slot < 0) begin
            // drop the write when every overlay page is taken
            if (pages_used >= PAGE_SLOTS) begin
              r.out_of_pages = 1'b1;
              return r;
            end
            slot = pages_used;
            pages_used++;
            page_tags[slot] = tag;
            for (int j = 0; j < PAGE_BYTES; j++)
              page_data[slot][j] = code_byte({tag, 5'(j)}, pg == 8'h01);
          end
          page_data[slot][pos] = val;
        end
      end
      return r;
    endfunction

    function void note_access(logic [1:0] mode, logic [15:0] addr, logic [7:0] val);
      pending_results.push_back(predict_access(mode, addr, val));
    endfunction

    function void check_result(logic [31:0] tdata, logic [1:0] tuser);
      omm_pkg::result_t got;
      omm_pkg::result_t want;
      got = '0;
      got.read_data = tdata[7:0];
      got.io_offset = tdata[15:8];
      got.io_data = tdata[23:16];
      got.out_of_pages = tdata[24];
      got.io_access = tuser[0];
      got.io_is_write = tuser[1];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: tdata=%h tuser=%b", tdata, tuser);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result mismatch: expected rd=%h io=%b off=%h wr=%b data=%h oop=%b",
                   want.read_data, want.io_access, want.io_offset, want.io_is_write,
                   want.io_data, want.out_of_pages);
          $display("                 got      rd=%h io=%b off=%h wr=%b data=%h oop=%b",
                   got.read_data, got.io_access, got.io_offset, got.io_is_write,
                   got.io_data, got.out_of_pages);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;

  bus_result_board board;
  bit send_idle_on;
  bit recv_idle_on;
  bit hold_request;
  int stall_count;

  overlay_memory_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) board.note_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // Receiver: random gaps per result, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      gap = recv_idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_access(logic [1:0] mode, logic [15:0] addr, logic [7:0] val);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {val, addr};
    in_tuser <= mode;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the input until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_code_length(logic [7:0] len);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    board.set_code_length(len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_address();
    int kind;
    logic [7:0] off;
    kind = $urandom_range(0, 99);
    off = 8'($urandom);
    if (kind < 12) return {omm_pkg::PAGE_ZERO, off};
    if (kind < 22) return {omm_pkg::PAGE_IO, off};
    if (kind < 30) return {omm_pkg::PAGE_VEC, $urandom_range(0, 1) ? off : (off | 8'hf0)};
    if (kind < 38) return {8'h01, off};
    if (kind < 60) return 16'(omm_pkg::CODE_BASE + $urandom_range(0, 300));
    if (kind < 85 && board.pages_used > 0)
      return {board.page_tags[$urandom_range(0, board.pages_used - 1)], 5'($urandom)};
    return 16'($urandom);
  endfunction

  task automatic send_random_access();
    int pick;
    logic [1:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 42) mode = omm_pkg::MODE_READ;
    else if (pick < 80) mode = omm_pkg::MODE_WRITE;
    else if (pick < 95) mode = omm_pkg::MODE_LOAD;
    else mode = omm_pkg::MODE_NONE;
    if (mode == omm_pkg::MODE_LOAD || mode == omm_pkg::MODE_NONE)
      send_access(mode, 16'($urandom), 8'($urandom));
    else
      send_access(mode, pick_address(), 8'($urandom));
  endtask

  initial begin : stimulus
    logic [7:0] lengths [4];
    board = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = omm_pkg::MODE_READ;
    out_tready = 1'b0;
    send_idle_on = 1;
    recv_idle_on = 1;
    hold_request = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_code_length(8'd0);

    // load a short program, then the fixed pages with no program mapped
    send_access(omm_pkg::MODE_LOAD, 16'h0000, 8'hff);
    send_access(omm_pkg::MODE_LOAD, 16'hff01, 8'h00);
    send_access(omm_pkg::MODE_LOAD, 16'h0002, 8'ha5);
    send_access(omm_pkg::MODE_LOAD, 16'h5503, 8'h5a);
    send_access(omm_pkg::MODE_WRITE, 16'h00ff, 8'hff);
    send_access(omm_pkg::MODE_READ, 16'h00ff, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'h0000, 8'hff);
    send_access(omm_pkg::MODE_WRITE, 16'h02ff, 8'hff);
    send_access(omm_pkg::MODE_READ, 16'h0200, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'hffef, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'hfff0, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'hffff, 8'h00);
    send_access(omm_pkg::MODE_WRITE, 16'hffff, 8'hff);
    send_access(omm_pkg::MODE_NONE, 16'hffff, 8'hff);
    send_access(omm_pkg::MODE_READ, 16'h01ff, 8'h00);
    drain_results();
    write_code_length(8'd4);

    // program reads, edge of the program, and page allocation of each fill kind
    send_access(omm_pkg::MODE_READ, 16'h0300, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'h0303, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'h0304, 8'h00);
    send_access(omm_pkg::MODE_WRITE, 16'h0301, 8'h77);
    send_access(omm_pkg::MODE_READ, 16'h0302, 8'h00);
    send_access(omm_pkg::MODE_READ, 16'h0301, 8'h00);
    send_access(omm_pkg::MODE_WRITE, 16'h0110, 8'h3c);
    send_access(omm_pkg::MODE_READ, 16'h011f, 8'h00);
    send_access(omm_pkg::MODE_WRITE, 16'hfee0, 8'h01);
    send_access(omm_pkg::MODE_READ, 16'hfeff, 8'h00);
    drain_results();

    // full program load so that any program length reads loaded bytes only
    for (int i = 0; i < 256; i++) begin
      if (i % 64 == 0) send_idle_on = $urandom_range(0, 3) != 0;
      send_access(omm_pkg::MODE_LOAD, {8'($urandom), 8'(i)}, 8'($urandom));
    end

    lengths = '{8'd255, 8'($urandom), 8'd0, 8'($urandom_range(1, 31))};
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_code_length(lengths[ph]);
      recv_idle_on = ph != 2;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 32 == 0) send_idle_on = $urandom_range(0, 3) != 0;
        if (ph == 0 && n == 50) hold_request = 1;
        if (ph == 1 && n == 60) drain_results();
        send_random_access();
      end
    end

    drain_results();
    repeat (PAGE_BYTES + 8) @(posedge clk);
    if (board.mismatches + board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* overlay_memory_map.f */
+incdir+src
src/omm_pkg.sv
src/omm_ram.sv
src/omm_tags.sv
src/overlay_memory_map.sv
src/omm_checker.sv
sim/overlay_memory_map_test.sv
